// File: hw/rtl/asfd_pkg.sv
// asfd_pkg: shared types and constants for the async serial frame decoder
// configuration register indexes, register widths and the config struct
// no dependencies
package asfd_pkg;

	localparam int DEF_MAX_WORD_LEN = 8;
	localparam int MIN_WORD_LEN     = 5;
	localparam int CHAR_W           = 8;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 4;
	localparam int COUNT_W          = 4;

	localparam logic [CFG_DATA_W-1:0] RST_WORD_LEN = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WORD_LEN   = 2'd0,
		CFG_PARITY_EN  = 2'd1,
		CFG_PARITY_ODD = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] word_len;
		logic                  parity_enable;
		logic                  parity_odd;
	} cfg_t;

endpackage

// File: hw/rtl/asfd_rx_core.sv
// asfd_rx_core: bit window, bit counter, frame and parity check
// produces at most one character per accepted line bit, same cycle
// depends on asfd_pkg
module asfd_rx_core #(
	parameter int MAX_WORD_LEN = asfd_pkg::DEF_MAX_WORD_LEN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  asfd_pkg::cfg_t              cfg,
	input  logic                        accept,
	input  logic                        line_bit,
	output logic                        res_valid,
	output logic [asfd_pkg::CHAR_W-1:0] res_data
);

	localparam int WIN_W = MAX_WORD_LEN + 3;
	localparam int IDX_W = $clog2(WIN_W);
	localparam int CW    = asfd_pkg::COUNT_W;

	logic [WIN_W-1:0] window_q;
	logic [CW-1:0]    count_q;

	logic [WIN_W-1:0] win_next;
	logic [WIN_W-1:0] win_shr;
	logic [CW-1:0]    nd;
	logic [CW-1:0]    w_m1;
	logic             check;
	logic             framed;
	logic             par;
	logic [CW-1:0]    count_next;

	always_comb begin
		// clamp data width into the supported range
		if (cfg.word_len < CW'(asfd_pkg::MIN_WORD_LEN)) begin
			nd = CW'(asfd_pkg::MIN_WORD_LEN);
		end else if (cfg.word_len > CW'(MAX_WORD_LEN)) begin
			nd = CW'(MAX_WORD_LEN);
		end else begin
			nd = cfg.word_len;
		end
		w_m1     = nd + CW'(1) + CW'(cfg.parity_enable);
		win_next = {window_q[WIN_W-2:0], line_bit};
		check    = count_q >= w_m1;
		framed   = check && win_next[0] && !win_next[w_m1[IDX_W-1:0]];

		// data sits above the stop bit, and above the parity bit when present
		win_shr = cfg.parity_enable ? (win_next >> 2) : (win_next >> 1);
		for (int j = 0; j < asfd_pkg::CHAR_W; j++) begin
			res_data[j] = (CW'(j) < nd) ? win_shr[j] : 1'b0;
		end

		// parity over the data bits and the parity bit itself
		par = cfg.parity_odd;
		for (int j = 1; j <= MAX_WORD_LEN + 1; j++) begin
			if (CW'(j) <= nd + CW'(1)) begin
				par = par ^ win_next[j];
			end
		end

		res_valid = accept && framed && (!cfg.parity_enable || !par);

		if (!check) begin
			count_next = count_q + CW'(1);
		end else if (framed) begin
			count_next = '0;
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
		end else if (accept) begin
			window_q <= win_next;
			count_q  <= count_next;
		end
	end

endmodule

// File: hw/rtl/async_serial_frame_decoder_top.sv
// async_serial_frame_decoder_top: serial receive frame decoder, top level
// holds configuration registers and the output register with skid stage
// depends on asfd_pkg and asfd_rx_core
//
// Usage:
// - input channel (in_valid, in_ready, line_bit) carries one sampled line bit
//   per transaction; a bit can be taken in every cycle while the skid stage is empty
// - output channel (out_valid, out_ready, char_data) carries one character for
//   each complete frame (zero start, data msb first, optional parity, one stop)
//   whose parity is good; bad parity frames are dropped
// - the character is registered after the stop bit's transaction, in the
//   output register or, on a stall, the skid stage; throughput is one line bit
//   per cycle while the skid stage is empty, set by the core's window update
// - when the receiver stalls, one more character is held in a skid stage;
//   in_ready falls only while the skid stage is full
// - cfg_write/cfg_index/cfg_data write the word length (0), parity_enable (1)
//   and parity_odd (2); other indexes are ignored
// - reset clears the window, the bit count and both output stages, and sets
//   the word length to 8 with parity off
module async_serial_frame_decoder_top #(
	parameter int MAX_WORD_LEN = asfd_pkg::DEF_MAX_WORD_LEN
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [asfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              line_bit,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [asfd_pkg::CHAR_W-1:0]       char_data
);

	asfd_pkg::cfg_t cfg_q;

	logic                        accept;
	logic                        res_valid;
	logic [asfd_pkg::CHAR_W-1:0] res_data;
	logic                        out_valid_q;
	logic [asfd_pkg::CHAR_W-1:0] out_data_q;
	logic                        skid_valid_q;
	logic [asfd_pkg::CHAR_W-1:0] skid_data_q;
	logic                        out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.word_len      <= asfd_pkg::RST_WORD_LEN;
			cfg_q.parity_enable <= 1'b0;
			cfg_q.parity_odd    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				asfd_pkg::CFG_WORD_LEN:   cfg_q.word_len      <= cfg_data;
				asfd_pkg::CFG_PARITY_EN:  cfg_q.parity_enable <= cfg_data[0];
				asfd_pkg::CFG_PARITY_ODD: cfg_q.parity_odd    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	asfd_rx_core #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.line_bit (line_bit),
		.res_valid(res_valid),
		.res_data (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_ready) begin
				skid_data_q <= res_data;
			end else begin
				out_data_q <= res_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_data = out_data_q;

	// skid stage is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full while output register empty");

	// a character only comes from an accepted line bit
	a_res_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (in_valid && in_ready))
		else $error("character produced without an input transaction");

	// skid stage fills only when the output was stalled
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid stage filled without a stall");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for async_serial_frame_decoder_top
// drives line bits and register writes, predicts characters from its own frame decoder
// depends on asfd_pkg and the rtl of the frame decoder
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// index that maps to no register, the block must ignore writes to it
	localparam logic [asfd_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
	localparam int HOLD_CYCLES = 300;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_write;
	logic [asfd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [asfd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic                            line_bit;
	logic                            out_valid;
	logic                            out_ready;
	logic [asfd_pkg::CHAR_W-1:0]     char_data;

	// shadow of the configuration registers and of the receive state
	logic [asfd_pkg::CFG_DATA_W-1:0] shadow_word_len;
	logic                            shadow_par_en;
	logic                            shadow_par_odd;
	logic [10:0]                     rx_window;
	logic [asfd_pkg::COUNT_W-1:0]    rx_count;

	logic [asfd_pkg::CHAR_W-1:0] pending_chars[$];

	int mismatch_count;
	int bits_sent;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;

	async_serial_frame_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.line_bit  (line_bit),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_data (char_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int eff_word_len();
		if (shadow_word_len < asfd_pkg::MIN_WORD_LEN)
			return asfd_pkg::MIN_WORD_LEN;
		if (shadow_word_len > asfd_pkg::DEF_MAX_WORD_LEN)
			return asfd_pkg::DEF_MAX_WORD_LEN;
		return int'(shadow_word_len);
	endfunction

	// shift one line bit into the window and queue the character it completes
	task automatic decode_line_bit(input logic b);
		int nd;
		int w;
		int word;
		logic p;
		nd = eff_word_len();
		w = nd + 2 + int'(shadow_par_en);
		rx_window = {rx_window[9:0], b};
		if (int'(rx_count) >= w - 1) begin
			if (!rx_window[w-1] && rx_window[0]) begin
				word = (int'(rx_window) & ((1 << w) - 1)) >> 1;
				if (shadow_par_en) begin
					p = shadow_par_odd;
					for (int j = 0; j <= nd; j++)
						p ^= word[j];
					if (!p)
						pending_chars.push_back(asfd_pkg::CHAR_W'(word >> 1));
				end else begin
					pending_chars.push_back(asfd_pkg::CHAR_W'(word));
				end
				rx_count = '0;
			end
		end else begin
			rx_count = rx_count + 1'b1;
		end
	endtask

	task automatic send_bit(input logic b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		line_bit <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bits_sent++;
		decode_line_bit(b);
	endtask

	// start, data msb first, optional parity, stop
	task automatic send_frame(input logic [7:0] data, input bit bad_par, input bit bad_stop);
		int nd;
		logic par;
		nd = eff_word_len();
		par = shadow_par_odd;
		send_bit(1'b0);
		for (int i = nd - 1; i >= 0; i--) begin
			send_bit(data[i]);
			par ^= data[i];
		end
		if (shadow_par_en)
			send_bit(par ^ bad_par);
		send_bit(!bad_stop);
	endtask

	task automatic stop_line();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// no transaction in flight and every character delivered
	task automatic settle();
		stop_line();
		while (pending_chars.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [asfd_pkg::CFG_IDX_W-1:0] idx,
			input logic [asfd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			asfd_pkg::CFG_WORD_LEN:   shadow_word_len = val;
			asfd_pkg::CFG_PARITY_EN:  shadow_par_en = val[0];
			asfd_pkg::CFG_PARITY_ODD: shadow_par_odd = val[0];
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults();
		send_frame(8'hFF, 1'b0, 1'b0);
	endtask

	task automatic test_width_clamp_parity();
		settle();
		write_reg(asfd_pkg::CFG_WORD_LEN, 4'd0);
		write_reg(asfd_pkg::CFG_PARITY_EN, 4'd1);
		write_reg(asfd_pkg::CFG_PARITY_ODD, 4'd1);
		send_frame(8'h00, 1'b0, 1'b0);
		// bad parity: dropped, count still restarts
		send_frame(8'h1F, 1'b1, 1'b0);
	endtask

	task automatic test_framing_midframe();
		settle();
		write_reg(asfd_pkg::CFG_WORD_LEN, 4'd15);
		write_reg(asfd_pkg::CFG_PARITY_ODD, 4'd0);
		write_reg(CFG_IDX_NONE, 4'hF);
		send_bit(1'b0);
		send_bit(1'b1);
		send_bit(1'b0);
		// width change part way through a frame
		settle();
		write_reg(asfd_pkg::CFG_WORD_LEN, 4'd5);
		send_frame(8'h15, 1'b0, 1'b1);
		send_bit(1'b1);
		send_bit(1'b1);
	endtask

	task automatic test_backpressure();
		settle();
		write_reg(asfd_pkg::CFG_WORD_LEN, 4'd8);
		write_reg(asfd_pkg::CFG_PARITY_EN, 4'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (8)
			send_frame(8'($urandom), 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_bits);
		int start;
		int kind;
		logic [7:0] d;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		start = bits_sent;
		while (bits_sent - start < n_bits) begin
			if ($urandom_range(5) == 0) begin
				settle();
				write_reg(asfd_pkg::CFG_IDX_W'($urandom_range(3)),
					asfd_pkg::CFG_DATA_W'($urandom_range(15)));
			end
			kind = $urandom_range(99);
			d = 8'($urandom);
			repeat ($urandom_range(3))
				send_bit(1'b1);
			if (kind < 70)
				send_frame(d, 1'b0, 1'b0);
			else if (kind < 80)
				send_frame(d, 1'b1, 1'b0);
			else if (kind < 88)
				send_frame(d, 1'b0, 1'b1);
			else
				repeat ($urandom_range(6, 1))
					send_bit(1'($urandom_range(1)));
		end
	endtask

	// receiver: random stalls plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h", char_data));
			end else begin
				if (char_data !== pending_chars[0])
					report_mismatch($sformatf("char_data 0x%02h, predicted 0x%02h",
						char_data, pending_chars[0]));
				void'(pending_chars.pop_front());
			end
		end
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = asfd_pkg::CFG_WORD_LEN;
		cfg_data = '0;
		in_valid = 1'b0;
		line_bit = 1'b0;
		hold_req = 1'b0;
		mismatch_count = 0;
		bits_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		shadow_word_len = asfd_pkg::RST_WORD_LEN;
		shadow_par_en = 1'b0;
		shadow_par_odd = 1'b0;
		rx_window = '0;
		rx_count = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_width_clamp_parity();
		test_framing_midframe();
		test_backpressure();

		settle();
		write_reg(asfd_pkg::CFG_WORD_LEN, 4'd5);
		write_reg(asfd_pkg::CFG_PARITY_EN, 4'd1);
		write_reg(asfd_pkg::CFG_PARITY_ODD, 4'd1);
		test_random_traffic(19, 81, 160);

		settle();
		write_reg(asfd_pkg::CFG_WORD_LEN, 4'd8);
		write_reg(asfd_pkg::CFG_PARITY_EN, 4'd1);
		write_reg(asfd_pkg::CFG_PARITY_ODD, 4'd0);
		test_random_traffic(81, 19, 160);

		test_random_traffic(0, 0, 160);

		stop_line();
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
